### sv/csb_pkg.sv
// ----------------------------------------------------------------------------
// Counting semaphore bank package
// Shared widths, defaults, status and request codes.
// ----------------------------------------------------------------------------
package csb_pkg;
   localparam int NUM_SEMS_DEF   = 16;
   localparam int POOL_DEPTH_DEF = 64;
   localparam int PROC_BITS_DEF  = 6;
   localparam int COUNT_BITS_DEF = 16;

   localparam int TYPE_W   = 2;
   localparam int INDEX_W  = 4;
   localparam int PID_W    = 6;
   localparam int INIT_W   = 16;
   localparam int STATUS_W = 2;

   localparam logic [TYPE_W-1:0] REQ_OPEN   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_WAIT   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_POST   = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd2;
endpackage

### sv/counting_semaphore_bank_top.sv
// ----------------------------------------------------------------------------
// Counting semaphore bank
// Semaphores with FIFO wait queues held in a shared node pool.
// ----------------------------------------------------------------------------
// Each request yields exactly one response. Open, wait and post pass through
// the read, execute and response states: the semaphore entry is read from a
// synchronous memory, then written back. A post that releases a waiter adds a
// dequeue state, because the head node is read before the entry is written back.
// A remove request walks every semaphore entry, reading and checking each one,
// and every node of a non-empty queue, reading and writing back each node, then
// responds, so its length grows with the number of queued nodes. The block
// handles one request at a time, and a new request is only taken once the
// previous response has been accepted. The node link and process stores are
// not cleared at reset; they are only read once written. The semaphore entry
// memory is swept clear entry by entry after reset, during which no request is
// accepted.
module counting_semaphore_bank_top #(
   parameter int NUM_SEMS   = csb_pkg::NUM_SEMS_DEF,
   parameter int POOL_DEPTH = csb_pkg::POOL_DEPTH_DEF,
   parameter int PROC_BITS  = csb_pkg::PROC_BITS_DEF,
   parameter int COUNT_BITS = csb_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [csb_pkg::TYPE_W-1:0]    req_type,
   input  logic [csb_pkg::INDEX_W-1:0]   req_sem_index,
   input  logic [csb_pkg::PID_W-1:0]     req_proc_id,
   input  logic [csb_pkg::INIT_W-1:0]    req_init_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [csb_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_woken_valid,
   output logic [csb_pkg::PID_W-1:0]     rsp_woken_proc,
   output logic [csb_pkg::INDEX_W-1:0]   rsp_handle
);
   localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int NW = $clog2(POOL_DEPTH);
   localparam int CNTW = $clog2(NUM_SEMS + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Semaphore entry, packed into one memory word.
   typedef struct packed {
      logic                  valid;
      logic                  empty;
      logic [NW-1:0]         head;
      logic [NW-1:0]         tail;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_EXEC, S_RM_ENT, S_RM_CHK, S_RM_NODE,
      S_RM_RD, S_RM_WB, S_RESP
   } state_type;

   entry_type sem_mem [NUM_SEMS];
   logic [NW-1:0]        node_next [POOL_DEPTH];
   logic [PROC_BITS-1:0] node_proc [POOL_DEPTH];

   state_type state_ff;
   logic [CNTW-1:0] sidx_ff;
   logic [POOL_DEPTH-1:0] free_ff;
   logic [csb_pkg::TYPE_W-1:0] type_ff;
   logic [csb_pkg::INDEX_W-1:0] idx_ff;
   logic [PROC_BITS-1:0] pid_ff;
   logic [COUNT_BITS-1:0] init_ff;
   entry_type ent_ff, ent_rd_ff;
   logic [NW-1:0] nnext_rd_ff, cur_ff, prev_ff;
   logic [PROC_BITS-1:0] nproc_rd_ff;
   logic has_prev_ff;

   logic rsp_valid_ff, wv_ff;
   logic [csb_pkg::STATUS_W-1:0] st_ff;
   logic [csb_pkg::PID_W-1:0] wp_ff;
   logic [csb_pkg::INDEX_W-1:0] hd_ff;

   // Second half of a blocking wait: link the old tail to the new node.
   logic link_pend_ff;
   logic [NW-1:0] link_from_ff, link_to_ff;

   // Memory port controls, driven by the sequencer.
   logic sem_we, node_we, nnext_we;
   logic [SW-1:0] sem_wa, sem_ra;
   entry_type sem_wd;
   logic [NW-1:0] node_wa, nnext_wa, nnext_wd, node_ra;

   // Lowest free node.
   logic [NW-1:0] free_n;
   logic free_any;
   always_comb begin
      free_n = '0;
      free_any = 1'b0;
      for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            free_n = NW'(i);
            free_any = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sem_we) sem_mem[sem_wa] <= sem_wd;
      ent_rd_ff <= sem_mem[sem_ra];
      if (node_we) node_proc[node_wa] <= pid_ff;
      if (nnext_we) node_next[nnext_wa] <= nnext_wd;
      nnext_rd_ff <= node_next[node_ra];
      nproc_rd_ff <= node_proc[node_ra];
   end

   wire in_range = ({{(32-csb_pkg::INDEX_W){1'b0}}, idx_ff} < 32'(NUM_SEMS));
   wire last_node = (cur_ff == ent_ff.tail);
   wire last_sem = (sidx_ff == CNTW'(NUM_SEMS - 1));

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;

   always_comb begin
      sem_we = 1'b0;
      sem_wa = idx_ff[SW-1:0];
      sem_wd = ent_ff;
      sem_ra = (state_ff == S_READ) ? idx_ff[SW-1:0] : sidx_ff[SW-1:0];
      node_we = 1'b0;
      node_wa = free_n;
      nnext_we = 1'b0;
      nnext_wa = free_n;
      nnext_wd = '0;
      node_ra = (state_ff == S_EXEC) ? ent_rd_ff.head : cur_ff;
      case (state_ff)
         S_CLEAR: begin
            sem_we = 1'b1;
            sem_wa = sidx_ff[SW-1:0];
            sem_wd = '{valid: 1'b0, empty: 1'b1, head: '0, tail: '0, count: '0};
         end
         S_EXEC: begin
            if (in_range) begin
               if (type_ff == csb_pkg::REQ_OPEN && !ent_rd_ff.valid) begin
                  sem_we = 1'b1;
                  sem_wd = ent_rd_ff;
                  sem_wd.valid = 1'b1;
                  sem_wd.empty = 1'b1;
                  sem_wd.count = init_ff;
               end else if (type_ff == csb_pkg::REQ_WAIT && ent_rd_ff.valid) begin
                  sem_wd = ent_rd_ff;
                  if (ent_rd_ff.count != '0) begin
                     sem_we = 1'b1;
                     sem_wd.count = ent_rd_ff.count - 1'b1;
                  end else if (free_any) begin
                     sem_we = 1'b1;
                     node_we = 1'b1;
                     nnext_we = 1'b1;
                     if (ent_rd_ff.empty) begin
                        sem_wd.head = free_n;
                        sem_wd.empty = 1'b0;
                     end
                     sem_wd.tail = free_n;
                  end
               end else if (type_ff == csb_pkg::REQ_POST && ent_rd_ff.valid &&
                            ent_rd_ff.empty && ent_rd_ff.count != COUNT_MAX) begin
                  sem_we = 1'b1;
                  sem_wd = ent_rd_ff;
                  sem_wd.count = ent_rd_ff.count + 1'b1;
               end
            end
         end
         S_RM_NODE: begin
            // Post dequeue: the head node's link becomes the new head, or the queue empties if it held one node.
            sem_we = 1'b1;
            if (ent_ff.head == ent_ff.tail) sem_wd.empty = 1'b1;
            else sem_wd.head = nnext_rd_ff;
         end
         S_RM_WB: begin
            // The entry is written back once its whole queue has been walked.
            sem_we = last_node;
            sem_wa = sidx_ff[SW-1:0];
            if (nproc_rd_ff == pid_ff) begin
               if (!has_prev_ff) begin
                  if (last_node) sem_wd.empty = 1'b1;
                  else sem_wd.head = nnext_rd_ff;
               end else begin
                  nnext_we = 1'b1;
                  nnext_wa = prev_ff;
                  nnext_wd = nnext_rd_ff;
                  if (last_node) sem_wd.tail = prev_ff;
               end
            end
         end
         default: ;
      endcase
      if (link_pend_ff) begin
         nnext_we = 1'b1;
         nnext_wa = link_from_ff;
         nnext_wd = link_to_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sidx_ff <= '0;
         free_ff <= '1;
         rsp_valid_ff <= 1'b0;
         link_pend_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               sidx_ff <= sidx_ff + 1'b1;
               if (last_sem) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid && !rsp_valid_ff) begin
                  type_ff <= req_type;
                  idx_ff <= req_sem_index;
                  pid_ff <= req_proc_id[PROC_BITS-1:0];
                  init_ff <= req_init_value[COUNT_BITS-1:0];
                  sidx_ff <= '0;
                  state_ff <= (req_type == csb_pkg::REQ_REMOVE) ? S_RM_ENT : S_READ;
               end
            end
            S_READ: state_ff <= S_EXEC;
            S_EXEC: begin
               st_ff <= csb_pkg::ST_OK;
               wv_ff <= 1'b0;
               wp_ff <= '0;
               hd_ff <= '0;
               ent_ff <= ent_rd_ff;
               state_ff <= S_RESP;
               if (!in_range) begin
                  st_ff <= csb_pkg::ST_ERROR;
               end else if (type_ff == csb_pkg::REQ_OPEN) begin
                  hd_ff <= idx_ff;
               end else if (!ent_rd_ff.valid) begin
                  st_ff <= csb_pkg::ST_ERROR;
               end else if (type_ff == csb_pkg::REQ_WAIT) begin
                  if (ent_rd_ff.count == '0) begin
                     if (!free_any) begin
                        st_ff <= csb_pkg::ST_ERROR;
                     end else begin
                        st_ff <= csb_pkg::ST_BLOCKED;
                        free_ff[free_n] <= 1'b0;
                        link_pend_ff <= !ent_rd_ff.empty;
                        link_from_ff <= ent_rd_ff.tail;
                        link_to_ff <= free_n;
                     end
                  end
               end else if (!ent_rd_ff.empty) begin
                  // Post with waiters: head node is read this cycle.
                  state_ff <= S_RM_NODE;
               end
            end
            S_RM_NODE: begin
               // Post dequeue, head node data now available.
               wv_ff <= 1'b1;
               wp_ff <= csb_pkg::PID_W'(nproc_rd_ff);
               free_ff[ent_ff.head] <= 1'b1;
               state_ff <= S_RESP;
            end
            S_RM_ENT: state_ff <= S_RM_CHK;
            S_RM_CHK: begin
               ent_ff <= ent_rd_ff;
               cur_ff <= ent_rd_ff.head;
               has_prev_ff <= 1'b0;
               if (ent_rd_ff.empty) begin
                  if (last_sem) begin
                     st_ff <= csb_pkg::ST_OK;
                     wv_ff <= 1'b0;
                     wp_ff <= '0;
                     hd_ff <= '0;
                     state_ff <= S_RESP;
                  end else begin
                     sidx_ff <= sidx_ff + 1'b1;
                     state_ff <= S_RM_ENT;
                  end
               end else begin
                  state_ff <= S_RM_RD;
               end
            end
            S_RM_RD: state_ff <= S_RM_WB;
            S_RM_WB: begin
               // Node data for cur_ff was read in the previous cycle.
               ent_ff <= sem_wd;
               if (nproc_rd_ff == pid_ff) begin
                  free_ff[cur_ff] <= 1'b1;
               end else begin
                  prev_ff <= cur_ff;
                  has_prev_ff <= 1'b1;
               end
               cur_ff <= nnext_rd_ff;
               if (last_node) begin
                  if (last_sem) begin
                     st_ff <= csb_pkg::ST_OK;
                     wv_ff <= 1'b0;
                     wp_ff <= '0;
                     hd_ff <= '0;
                     state_ff <= S_RESP;
                  end else begin
                     sidx_ff <= sidx_ff + 1'b1;
                     state_ff <= S_RM_ENT;
                  end
               end else begin
                  state_ff <= S_RM_RD;
               end
            end
            S_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (link_pend_ff) link_pend_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = st_ff;
   assign rsp_woken_valid = wv_ff;
   assign rsp_woken_proc = wp_ff;
   assign rsp_handle = hd_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("response dropped");
   a_woken_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_woken_valid |-> rsp_status == csb_pkg::ST_OK)
      else $error("wake with non-ok status");
`endif
endmodule
